// ===== design/osut_pkg.sv =====
`default_nettype none
package osut_pkg;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RM_POS    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RM_KEY    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RM_LAST   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [KEY_W-1:0]    read_key;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  // per-cycle command to every cell
  typedef struct packed {
    logic apply;
    logic add;
    logic drop;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/osut_if.sv =====
`default_nettype none
interface osut_in_if;
  logic               valid;
  logic               ready;
  osut_pkg::in_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface osut_out_if;
  logic                valid;
  logic                ready;
  osut_pkg::out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/osut_cell.sv =====
`default_nettype none
module osut_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int IW        = 4,
  parameter int CW        = 5,
  parameter int INDEX     = 0
) (
  input  wire logic                      clk,
  input  wire logic [KEY_WIDTH-1:0]      key_i,
  input  wire logic [osut_pkg::POS_W-1:0] pos_i,
  input  wire logic [KEY_WIDTH-1:0]      next_key_i,
  input  wire logic [CW-1:0]             count_i,
  input  wire logic [IW-1:0]             tgt_i,
  input  wire osut_pkg::cell_ctl_t       ctl_i,
  output logic [KEY_WIDTH-1:0]           key_o,
  output logic                           match_o,
  output logic [IW-1:0]                  idx_o,
  output logic [KEY_WIDTH-1:0]           rd_o
);

  logic [KEY_WIDTH-1:0] entry_r;
  logic [KEY_WIDTH-1:0] entry_nxt;
  logic                 live;

  assign live    = CW'(INDEX) < count_i;
  assign match_o = live && (entry_r == key_i);
  assign idx_o   = match_o ? IW'(INDEX) : '0;
  assign rd_o    = (live && (INDEX == int'(pos_i))) ? entry_r : '0;
  assign key_o   = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.apply && ctl_i.add && (count_i == CW'(INDEX))) begin
      entry_nxt = key_i;
    end else if (ctl_i.apply && ctl_i.drop && (IW'(INDEX) >= tgt_i)) begin
      entry_nxt = next_key_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== design/ordered_unique_set_table_unit.sv =====
// a command accepted when idle is latched, searched across all cells in the look state
// and applied in the apply state; the next is taken once idle with the output free
// a remove shifts every cell at or above the target down one place in the apply state
// reset: synchronous active-low rst_n empties the table (count zero) and the output register
// table contents are not cleared, only positions below the count are ever read
`default_nettype none
module ordered_unique_set_table_unit #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  osut_in_if.sink    in_chan,
  osut_out_if.source out_chan
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;
  osut_pkg::out_item_t out_r;

  logic [osut_pkg::CMD_W-1:0] cmd_r;
  logic [KEY_WIDTH-1:0]       key_r;
  logic [osut_pkg::POS_W-1:0] pos_r;

  logic [IW-1:0] tgt_r, tgt_nxt;
  logic add_r, add_nxt, drop_r, drop_nxt, clr_r, clr_nxt;
  logic [osut_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [osut_pkg::POS_W-1:0]    fpos_r, fpos_nxt;
  logic [osut_pkg::KEY_W-1:0]    rkey_r, rkey_nxt;

  logic in_fire;
  osut_pkg::cell_ctl_t ctl;

  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [KEY_WIDTH-1:0] cell_rd  [DEPTH];
  logic [IW-1:0]        cell_idx [DEPTH];
  logic [DEPTH-1:0]     cell_match;

  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic [KEY_WIDTH-1:0] rd_bus;
  logic                 key_zero;
  logic                 pos_ok;

  assign in_chan.ready  = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.payload = out_r;

  assign ctl.apply = state_r == S_APPLY;
  assign ctl.add   = add_r;
  assign ctl.drop  = drop_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] next_key;
    if (i == DEPTH - 1) begin : g_last
      assign next_key = '0;
    end else begin : g_mid
      assign next_key = cell_key[i+1];
    end
    osut_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .IW(IW),
      .CW(CW),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .key_i(key_r),
      .pos_i(pos_r),
      .next_key_i(next_key),
      .count_i(count_r),
      .tgt_i(tgt_r),
      .ctl_i(ctl),
      .key_o(cell_key[i]),
      .match_o(cell_match[i]),
      .idx_o(cell_idx[i]),
      .rd_o(cell_rd[i])
    );
  end

  // keys are distinct, so at most one cell matches and the index is a plain or
  always_comb begin
    hit_idx = '0;
    rd_bus  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | cell_idx[i];
      rd_bus  = rd_bus | cell_rd[i];
    end
  end

  assign hit      = |cell_match;
  assign key_zero = key_r == '0;
  assign pos_ok   = 32'(pos_r) < 32'(count_r);

  always_comb begin
    status_nxt = osut_pkg::ST_DONE;
    fpos_nxt   = '0;
    rkey_nxt   = '0;
    tgt_nxt    = '0;
    add_nxt    = 1'b0;
    drop_nxt   = 1'b0;
    clr_nxt    = 1'b0;
    case (cmd_r)
      osut_pkg::CMD_ADD: begin
        if (key_zero) begin
          status_nxt = osut_pkg::ST_ZERO;
        end else if (hit) begin
          status_nxt = osut_pkg::ST_PRESENT;
        end else if (count_r == CW'(DEPTH)) begin
          status_nxt = osut_pkg::ST_FULL;
        end else begin
          add_nxt = 1'b1;
        end
      end
      osut_pkg::CMD_FIND: begin
        if (key_zero) begin
          status_nxt = osut_pkg::ST_ZERO;
        end else if (!hit) begin
          status_nxt = osut_pkg::ST_ABSENT;
        end else begin
          fpos_nxt = osut_pkg::POS_W'(hit_idx);
        end
      end
      osut_pkg::CMD_READ: begin
        if (pos_ok) begin
          rkey_nxt = osut_pkg::KEY_W'(rd_bus);
        end else begin
          status_nxt = osut_pkg::ST_ABSENT;
        end
      end
      osut_pkg::CMD_RM_POS: begin
        if (pos_ok) begin
          drop_nxt = 1'b1;
          tgt_nxt  = IW'(pos_r);
        end else begin
          status_nxt = osut_pkg::ST_ABSENT;
        end
      end
      osut_pkg::CMD_RM_KEY: begin
        if (key_zero) begin
          status_nxt = osut_pkg::ST_ZERO;
        end else if (!hit) begin
          status_nxt = osut_pkg::ST_ABSENT;
        end else begin
          drop_nxt = 1'b1;
          tgt_nxt  = hit_idx;
        end
      end
      osut_pkg::CMD_RM_LAST: begin
        if (count_r != '0) begin
          drop_nxt = 1'b1;
          tgt_nxt  = IW'(count_r - CW'(1));
        end else begin
          status_nxt = osut_pkg::ST_ABSENT;
        end
      end
      osut_pkg::CMD_CLEAR: begin
        clr_nxt = 1'b1;
      end
      default: begin
        status_nxt = osut_pkg::ST_ABSENT;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (clr_r) begin
          count_nxt = '0;
        end else if (add_r) begin
          count_nxt = count_r + CW'(1);
        end else if (drop_r) begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      add_r       <= 1'b0;
      drop_r      <= 1'b0;
      clr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_LOOK) begin
        add_r  <= add_nxt;
        drop_r <= drop_nxt;
        clr_r  <= clr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_chan.payload.cmd;
      key_r <= KEY_WIDTH'(in_chan.payload.key);
      pos_r <= in_chan.payload.position;
    end
    if (state_r == S_LOOK) begin
      status_r <= status_nxt;
      fpos_r   <= fpos_nxt;
      rkey_r   <= rkey_nxt;
      tgt_r    <= tgt_nxt;
    end
    if (state_r == S_APPLY) begin
      out_r.status         <= status_r;
      out_r.found_position <= fpos_r;
      out_r.read_key       <= rkey_r;
      out_r.entry_count    <= osut_pkg::COUNT_W'(count_nxt);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_fire_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_LOOK)
    else $error("accepted transaction did not start search");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (state_r == S_IDLE))
    else $error("ready while busy");

  a_out_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_APPLY)
    else $error("result without apply cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && clr_r |=> count_r == '0)
    else $error("clear left entries");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;

  localparam logic [osut_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int SET_DEPTH    = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 440;
  localparam int FLOOD_ITEMS  = 90;
  localparam int FLOOD_HOLD   = 120;
  localparam osut_pkg::out_item_t NO_PIN = '0;

  typedef struct {
    bit                  pinned;
    osut_pkg::out_item_t res;
  } pin_t;

  typedef struct {
    osut_pkg::in_item_t  item;
    bit                  pinned;
    osut_pkg::out_item_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  osut_in_if  in_chan ();
  osut_out_if out_chan ();

  ordered_unique_set_table_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // table state as the testbench sees it
  logic [osut_pkg::KEY_W-1:0] set_keys [SET_DEPTH];
  int                         set_len;
  bit                         growing;

  osut_pkg::out_item_t expected_results [$];
  pin_t                pinned_q [$];
  int                  mismatches;
  int                  quiet_cycles;
  int                  src_idle_pct;
  int                  sink_stall_pct;
  logic                hold_out;

  dir_row_t dir_rows [25] = '{
    '{'{osut_pkg::CMD_READ,    32'h0000_0000, 4'd0},  1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_RM_LAST, 32'hFFFF_FFFF, 4'd15}, 1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_RM_POS,  32'h0000_0000, 4'd0},  1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_FIND,    32'hFFFF_FFFF, 4'd0},  1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_ADD,     32'h0000_0000, 4'd15}, 1'b1,
      '{osut_pkg::ST_ZERO,    4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_FIND,    32'h0000_0000, 4'd0},  1'b1,
      '{osut_pkg::ST_ZERO,    4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_RM_KEY,  32'h0000_0000, 4'd0},  1'b1,
      '{osut_pkg::ST_ZERO,    4'd0, 32'h0, 5'd0}},
    '{'{CMD_UNUSED,            32'hFFFF_FFFF, 4'd15}, 1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_ADD,     32'hFFFF_FFFF, 4'd0},  1'b1,
      '{osut_pkg::ST_DONE,    4'd0, 32'h0, 5'd1}},
    '{'{osut_pkg::CMD_ADD,     32'h0000_0001, 4'd0},  1'b1,
      '{osut_pkg::ST_DONE,    4'd0, 32'h0, 5'd2}},
    '{'{osut_pkg::CMD_ADD,     32'hFFFF_FFFF, 4'd0},  1'b1,
      '{osut_pkg::ST_PRESENT, 4'd0, 32'h0, 5'd2}},
    '{'{osut_pkg::CMD_ADD,     32'h8000_0000, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_READ,    32'h0000_0000, 4'd0},  1'b1,
      '{osut_pkg::ST_DONE,    4'd0, 32'hFFFF_FFFF, 5'd3}},
    '{'{osut_pkg::CMD_READ,    32'h0000_0000, 4'd15}, 1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd3}},
    '{'{osut_pkg::CMD_FIND,    32'h0000_0001, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_FIND,    32'h8000_0000, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_READ,    32'h0000_0000, 4'd3},  1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd3}},
    '{'{osut_pkg::CMD_RM_POS,  32'h0000_0000, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_READ,    32'h0000_0000, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_RM_KEY,  32'h1234_5678, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_RM_KEY,  32'h0000_0001, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_RM_LAST, 32'h0000_0000, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_ADD,     32'h5A5A_5A5A, 4'd0},  1'b0, NO_PIN},
    '{'{osut_pkg::CMD_CLEAR,   32'hFFFF_FFFF, 4'd15}, 1'b1,
      '{osut_pkg::ST_DONE,    4'd0, 32'h0, 5'd0}},
    '{'{osut_pkg::CMD_RM_POS,  32'h0000_0000, 4'd15}, 1'b1,
      '{osut_pkg::ST_ABSENT,  4'd0, 32'h0, 5'd0}}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int key_slot(logic [osut_pkg::KEY_W-1:0] key);
    for (int i = 0; i < set_len; i++) begin
      if (set_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int slot);
    for (int i = slot; i + 1 < set_len; i++) set_keys[i] = set_keys[i + 1];
    set_len--;
  endfunction

  // applies one command to the table and returns the result it should give
  function automatic osut_pkg::out_item_t run_table_cmd(osut_pkg::in_item_t c);
    osut_pkg::out_item_t r;
    int                  slot;
    r = '0;
    r.status = osut_pkg::ST_DONE;
    case (c.cmd)
      osut_pkg::CMD_ADD: begin
        if (c.key == '0) r.status = osut_pkg::ST_ZERO;
        else if (key_slot(c.key) >= 0) r.status = osut_pkg::ST_PRESENT;
        else if (set_len >= SET_DEPTH) r.status = osut_pkg::ST_FULL;
        else begin
          set_keys[set_len] = c.key;
          set_len++;
        end
      end
      osut_pkg::CMD_FIND: begin
        slot = key_slot(c.key);
        if (c.key == '0) r.status = osut_pkg::ST_ZERO;
        else if (slot < 0) r.status = osut_pkg::ST_ABSENT;
        else r.found_position = osut_pkg::POS_W'(slot);
      end
      osut_pkg::CMD_READ: begin
        if (int'(c.position) < set_len) r.read_key = set_keys[c.position];
        else r.status = osut_pkg::ST_ABSENT;
      end
      osut_pkg::CMD_RM_POS: begin
        if (int'(c.position) < set_len) drop_slot(int'(c.position));
        else r.status = osut_pkg::ST_ABSENT;
      end
      osut_pkg::CMD_RM_KEY: begin
        slot = key_slot(c.key);
        if (c.key == '0) r.status = osut_pkg::ST_ZERO;
        else if (slot < 0) r.status = osut_pkg::ST_ABSENT;
        else drop_slot(slot);
      end
      osut_pkg::CMD_RM_LAST: begin
        if (set_len > 0) drop_slot(set_len - 1);
        else r.status = osut_pkg::ST_ABSENT;
      end
      osut_pkg::CMD_CLEAR: set_len = 0;
      default: r.status = osut_pkg::ST_ABSENT;
    endcase
    r.entry_count = osut_pkg::COUNT_W'(set_len);
    return r;
  endfunction

  function automatic logic [osut_pkg::KEY_W-1:0] fresh_key();
    if ($urandom_range(3) == 0) return osut_pkg::KEY_W'($urandom_range(40, 1));
    return osut_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [osut_pkg::KEY_W-1:0] lookup_key();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 75 && set_len > 0) return set_keys[$urandom_range(set_len - 1, 0)];
    return fresh_key();
  endfunction

  // mostly valid table traffic: grow to full, then shrink back to empty
  function automatic osut_pkg::in_item_t next_cmd();
    osut_pkg::in_item_t c;
    int                 r;
    int                 sel;
    c.key      = osut_pkg::KEY_W'($urandom);
    c.position = osut_pkg::POS_W'($urandom_range(15));
    if (growing && set_len == SET_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
    if (!growing && set_len == 0) growing = 1'b1;
    r = $urandom_range(99);
    if (growing) sel = (r < 45) ? 0 : (r < 60) ? 1 : (r < 73) ? 2 : (r < 80) ? 3 :
                       (r < 88) ? 4 : (r < 97) ? 5 : (r < 98) ? 6 : 7;
    else sel = (r < 15) ? 0 : (r < 30) ? 1 : (r < 45) ? 2 : (r < 65) ? 3 :
               (r < 85) ? 4 : (r < 97) ? 5 : (r < 99) ? 6 : 7;
    case (sel)
      0: begin
        c.cmd = osut_pkg::CMD_ADD;
        r = $urandom_range(99);
        if (r < 4) c.key = '0;
        else if (r < 16 && set_len > 0) c.key = set_keys[$urandom_range(set_len - 1, 0)];
        else c.key = fresh_key();
      end
      1: begin
        c.cmd = osut_pkg::CMD_FIND;
        c.key = lookup_key();
      end
      2, 3: begin
        c.cmd = (sel == 2) ? osut_pkg::CMD_READ : osut_pkg::CMD_RM_POS;
        if (set_len > 0 && $urandom_range(99) < 75)
          c.position = osut_pkg::POS_W'($urandom_range(set_len - 1, 0));
      end
      4: begin
        c.cmd = osut_pkg::CMD_RM_KEY;
        c.key = lookup_key();
      end
      5: c.cmd = osut_pkg::CMD_RM_LAST;
      6: c.cmd = osut_pkg::CMD_CLEAR;
      default: c.cmd = CMD_UNUSED;
    endcase
    return c;
  endfunction

  task automatic offer(input osut_pkg::in_item_t item, input bit pinned,
                       input osut_pkg::out_item_t res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    pinned_q.push_back('{pinned, res});
    in_chan.valid   <= 1'b1;
    in_chan.payload <= item;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) offer(next_cmd(), 1'b0, NO_PIN);
  endtask

  task automatic report_field(input string name, input logic [osut_pkg::KEY_W-1:0] want,
                              input logic [osut_pkg::KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= !hold_out && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // transaction monitor, scoreboard and watchdog
  always @(posedge clk) begin
    osut_pkg::out_item_t want;
    osut_pkg::out_item_t pred;
    pin_t                pin;
    if (rst_n) begin
      quiet_cycles++;
      if (out_chan.valid && out_chan.ready) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result 0x%0h", $time, out_chan.payload);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("status", osut_pkg::KEY_W'(want.status),
                       osut_pkg::KEY_W'(out_chan.payload.status));
          report_field("found_position", osut_pkg::KEY_W'(want.found_position),
                       osut_pkg::KEY_W'(out_chan.payload.found_position));
          report_field("read_key", want.read_key, out_chan.payload.read_key);
          report_field("entry_count", osut_pkg::KEY_W'(want.entry_count),
                       osut_pkg::KEY_W'(out_chan.payload.entry_count));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        quiet_cycles = 0;
        pred = run_table_cmd(in_chan.payload);
        pin  = pinned_q.pop_front();
        expected_results.push_back(pin.pinned ? pin.res : pred);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.payload = '0;
    hold_out        = 1'b0;
    set_len         = 0;
    growing         = 1'b1;
    mismatches      = 0;
    quiet_cycles    = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].res);

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(74, 0, PHASE_ITEMS);
    run_phase(0, 74, PHASE_ITEMS);
    run_phase(29, 29, PHASE_ITEMS);

    // receiver blocked while the sender keeps pushing
    fork
      begin
        hold_out <= 1'b1;
        repeat (FLOOD_HOLD) @(negedge clk);
        hold_out <= 1'b0;
      end
      run_phase(0, 0, FLOOD_ITEMS);
    join

    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== ordered_unique_set_table_unit.f =====
design/osut_pkg.sv
design/osut_if.sv
design/osut_cell.sv
design/ordered_unique_set_table_unit.sv
tb/sv/tb_top.sv
